// ===== rtl/dwpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Package for the dual wheel speed PI controller
// Shared types, codes, register defaults and the sequencer program.
// ----------------------------------------------------------------------------
package dwpi_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_LEFT  = 2'd0,
    CMD_RIGHT = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MS   = 3'd0,
    CFG_SPEED_SCALE = 3'd1,
    CFG_HALF_TRACK  = 3'd2,
    CFG_GAIN_P      = 3'd3,
    CFG_GAIN_I      = 3'd4
  } cfg_idx_e;

  localparam int unsigned GAIN_W = 10;

  localparam logic [15:0]       PERIOD_RST = 16'd100;
  localparam logic [15:0]       SCALE_RST  = 16'd343;
  localparam logic [15:0]       TRACK_RST  = 16'd9093;
  localparam logic [GAIN_W-1:0] GAIN_P_RST = 10'd200;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 10'd100;

  localparam int unsigned SUM_W   = 24;
  localparam int unsigned DRIVE_W = 9;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned SPEED_W = 16;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MS_NONE   = 3'd0,
    MS_TRACK  = 3'd1,
    MS_TICKS  = 3'd2,
    MS_GAIN_P = 3'd3,
    MS_GAIN_I = 3'd4
  } mul_sel_e;

  // Sequencing of the step counter.
  typedef enum logic {
    SQ_NEXT = 1'b0,
    SQ_LOOP = 1'b1
  } seq_e;

  localparam int unsigned UC_PC_W = 3;

  typedef struct packed {
    mul_sel_e             mul_sel;
    logic                 ld_delta;
    logic                 ld_targ;
    logic                 ld_err;
    logic                 upd_sum;
    logic                 ld_acc;
    logic                 add_acc;
    logic                 ld_drive;
    seq_e                 seq;
    logic [UC_PC_W-1:0]   jump;
  } ucode_t;

  // First step of the per-wheel part of the program.
  localparam logic [UC_PC_W-1:0] UC_WHEEL_START = 3'd2;

  // Control store. Steps 0 and 1 split the turn rate into a wheel offset;
  // steps 2 to 7 run the PI update for one wheel and loop once.
  function automatic ucode_t ucode_at(logic [UC_PC_W-1:0] pc);
    ucode_t uc;
    uc = '{mul_sel: MS_NONE, seq: SQ_NEXT, jump: UC_WHEEL_START, default: 1'b0};
    unique case (pc)
      3'd0: uc.mul_sel = MS_TRACK;
      3'd1: uc.ld_delta = 1'b1;
      3'd2: begin
        uc.mul_sel = MS_TICKS;
        uc.ld_targ = 1'b1;
      end
      3'd3: uc.ld_err = 1'b1;
      3'd4: begin
        uc.mul_sel = MS_GAIN_P;
        uc.upd_sum = 1'b1;
      end
      3'd5: begin
        uc.mul_sel = MS_GAIN_I;
        uc.ld_acc  = 1'b1;
      end
      3'd6: uc.add_acc = 1'b1;
      3'd7: begin
        uc.ld_drive = 1'b1;
        uc.seq      = SQ_LOOP;
      end
      default: uc = uc;
    endcase
    return uc;
  endfunction

endpackage

// ===== rtl/dwpi_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel of the dual wheel speed PI controller
// Encoder edges and millisecond ticks with the current speed commands.
// ----------------------------------------------------------------------------
interface dwpi_in_if
  import dwpi_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic                      phase_b;
  logic signed [SPEED_W-1:0] target_speed;
  logic signed [SPEED_W-1:0] target_turn_rate;

  modport source (
    output valid, command, phase_b, target_speed, target_turn_rate,
    input  ready
  );
  modport sink (
    input  valid, command, phase_b, target_speed, target_turn_rate,
    output ready
  );
endinterface

// ===== rtl/dwpi_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel of the dual wheel speed PI controller
// One beat per control update: drive magnitude and direction per wheel.
// ----------------------------------------------------------------------------
interface dwpi_out_if
  import dwpi_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_duty;
  logic              left_reverse;
  logic [DUTY_W-1:0] right_duty;
  logic              right_reverse;

  modport source (
    output valid, left_duty, left_reverse, right_duty, right_reverse,
    input  ready
  );
  modport sink (
    input  valid, left_duty, left_reverse, right_duty, right_reverse,
    output ready
  );
endinterface

// ===== rtl/dual_wheel_speed_pi_controller_core.sv =====
// ----------------------------------------------------------------------------
// Dual wheel speed PI controller core
// Encoder edge counting, millisecond timer and a microcoded PI update per wheel.
// ----------------------------------------------------------------------------
// Edge and tick beats are taken one per cycle while no update is running.
// A tick that closes the period starts the program (2 shared steps,
// then 6 steps per wheel on one multiplier); input is held off meanwhile and
// the result beat is valid in the cycle after the last step.
// The last step waits while a previous result beat has not been taken.
// Reset clears counters, timer, integrators and drives, and loads defaults.
module dual_wheel_speed_pi_controller_core
  import dwpi_pkg::*;
#(
  parameter int unsigned TICK_COUNT_WIDTH = 16,
  parameter int unsigned SPEED_FRAC_BITS  = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dwpi_in_if.sink               in_i,
  dwpi_out_if.source            out_o
);

  localparam int unsigned TW     = TICK_COUNT_WIDTH;
  localparam int unsigned MEAS_W = TW + 9;
  localparam int unsigned TARG_W = 18;
  localparam int unsigned DELTA_W = 17;
  localparam int unsigned ERR_W  = ((MEAS_W > TARG_W) ? MEAS_W : TARG_W) + 1;
  localparam int unsigned OPA_W  = (ERR_W > SUM_W) ? ERR_W : SUM_W;
  localparam int unsigned OPB_W  = 17;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam int unsigned CMP_W  = (ERR_W > SUM_W + 1) ? ERR_W : SUM_W + 1;

  localparam logic signed [TW-1:0]    TICK_HI  = {1'b0, {(TW - 1){1'b1}}};
  localparam logic signed [TW-1:0]    TICK_LO  = {1'b1, {(TW - 1){1'b0}}};
  localparam logic signed [CMP_W-1:0] ERR_HI   = CMP_W'(64'sd16777215);
  localparam logic signed [CMP_W-1:0] ERR_LO   = -ERR_HI;
  localparam logic signed [SUM_W+1:0] SUM_HI   = (SUM_W + 2)'(64'sd8388607);
  localparam logic signed [SUM_W+1:0] SUM_LO   = (SUM_W + 2)'(-64'sd8388608);
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'sd1 <<< SPEED_FRAC_BITS) - 1);
  localparam logic signed [ACC_W-1:0] DRV_HI   = ACC_W'(64'sd255);
  localparam logic signed [ACC_W-1:0] DRV_LO   = ACC_W'(-64'sd255);
  localparam logic signed [DRIVE_W-1:0] DRV_MAX = 9'sd255;
  localparam logic signed [DRIVE_W-1:0] DRV_MIN = -9'sd255;

  // Configuration registers.
  logic [15:0]       period_q, scale_q, track_q;
  logic [GAIN_W-1:0] gain_p_q, gain_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      scale_q  <= SCALE_RST;
      track_q  <= TRACK_RST;
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD_MS:   period_q <= cfg_data_i;
        CFG_SPEED_SCALE: scale_q  <= cfg_data_i;
        CFG_HALF_TRACK:  track_q  <= cfg_data_i;
        CFG_GAIN_P:      gain_p_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:      gain_i_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and controller state.
  logic                       busy_q, busy_d;
  logic [UC_PC_W-1:0]         pc_q, pc_d;
  logic                       wheel_q, wheel_d;
  logic [15:0]                ms_q, ms_d;
  logic signed [TW-1:0]       lticks_q, lticks_d, rticks_q, rticks_d;
  logic signed [SUM_W-1:0]    lsum_q, lsum_d, rsum_q, rsum_d;
  logic signed [DRIVE_W-1:0]  ldrv_q, ldrv_d, rdrv_q, rdrv_d;
  logic                       oval_q, oval_d;

  // Datapath registers.
  logic signed [SPEED_W-1:0]  v_q, w_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [DELTA_W-1:0]  delta_q;
  logic signed [TARG_W-1:0]   targ_q;
  logic signed [ERR_W-1:0]    err_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [DUTY_W-1:0]          lduty_q, rduty_q;
  logic                       lrev_q, rrev_q;

  ucode_t                     uc;
  logic                       in_acc, out_free, finish;
  logic [15:0]                ms_inc;

  logic signed [OPA_W-1:0]    mul_a;
  logic signed [OPB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   prod_full, prod_rnd16, prod_rnd8;
  logic signed [MEAS_W-1:0]   meas;
  logic signed [TW-1:0]       ticks_sel;
  logic signed [SUM_W-1:0]    sum_sel, sum_new;
  logic signed [DRIVE_W-1:0]  drv_sel, drv_calc;
  logic signed [CMP_W-1:0]    err_w;
  logic signed [SUM_W:0]      err_c;
  logic signed [SUM_W+1:0]    sum_raw;
  logic signed [ACC_W-1:0]    acc_b, acc_s;
  logic [DRIVE_W-1:0]         lmag, rmag;

  assign uc       = ucode_at(pc_q);
  assign in_i.ready = !busy_q;
  assign in_acc   = in_i.valid && !busy_q;
  assign out_free = !oval_q || out_o.ready;
  assign finish   = busy_q && (uc.seq == SQ_LOOP) && wheel_q && out_free;
  assign ms_inc   = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;

  assign ticks_sel = wheel_q ? rticks_q : lticks_q;
  assign sum_sel   = wheel_q ? rsum_q : lsum_q;
  assign drv_sel   = wheel_q ? rdrv_q : ldrv_q;

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uc.mul_sel)
      MS_TRACK: begin
        mul_a = OPA_W'(w_q);
        mul_b = {1'b0, track_q};
      end
      MS_TICKS: begin
        mul_a = OPA_W'(ticks_sel);
        mul_b = {1'b0, scale_q};
      end
      MS_GAIN_P: begin
        mul_a = OPA_W'(err_q);
        mul_b = {{(OPB_W - GAIN_W){1'b0}}, gain_p_q};
      end
      MS_GAIN_I: begin
        mul_a = OPA_W'(sum_sel);
        mul_b = {{(OPB_W - GAIN_W){1'b0}}, gain_i_q};
      end
      MS_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: ;
    endcase
  end

  assign prod_full  = mul_a * mul_b;
  assign prod_rnd16 = prod_q + PROD_W'(64'sd32768);
  assign prod_rnd8  = prod_q + PROD_W'(64'sd128);
  assign meas       = prod_rnd8[8 +: MEAS_W];

  // Integrator step: the error is limited first, then the sum saturates.
  always_comb begin
    err_w = CMP_W'(err_q);
    if (err_w > ERR_HI) begin
      err_c = ERR_HI[SUM_W:0];
    end else if (err_w < ERR_LO) begin
      err_c = ERR_LO[SUM_W:0];
    end else begin
      err_c = err_w[SUM_W:0];
    end
    sum_raw = (SUM_W + 2)'(sum_sel) + (SUM_W + 2)'(err_c);
    if (sum_raw > SUM_HI) begin
      sum_new = SUM_HI[SUM_W-1:0];
    end else if (sum_raw < SUM_LO) begin
      sum_new = SUM_LO[SUM_W-1:0];
    end else begin
      sum_new = sum_raw[SUM_W-1:0];
    end
  end

  // Division by the fraction scale rounds toward zero before the clamp.
  always_comb begin
    acc_b = acc_q + (acc_q[ACC_W-1] ? TRUNC_BIAS : '0);
    acc_s = acc_b >>> SPEED_FRAC_BITS;
    if (acc_s > DRV_HI) begin
      drv_calc = DRV_MAX;
    end else if (acc_s < DRV_LO) begin
      drv_calc = DRV_MIN;
    end else begin
      drv_calc = acc_s[DRIVE_W-1:0];
    end
  end

  assign lmag = ldrv_q[DRIVE_W-1] ? DRIVE_W'(-ldrv_q) : ldrv_q;
  assign rmag = drv_calc[DRIVE_W-1] ? DRIVE_W'(-drv_calc) : drv_calc;

  // Control: command decode, step counter and controller state.
  always_comb begin
    busy_d   = busy_q;
    pc_d     = pc_q;
    wheel_d  = wheel_q;
    ms_d     = ms_q;
    lticks_d = lticks_q;
    rticks_d = rticks_q;
    lsum_d   = lsum_q;
    rsum_d   = rsum_q;
    ldrv_d   = ldrv_q;
    rdrv_d   = rdrv_q;
    oval_d   = oval_q && !out_o.ready;

    if (in_acc) begin
      priority if (in_i.command == CMD_LEFT) begin
        if (in_i.phase_b) begin
          if (lticks_q != TICK_HI) lticks_d = lticks_q + TW'(1);
        end else begin
          if (lticks_q != TICK_LO) lticks_d = lticks_q - TW'(1);
        end
      end else if (in_i.command == CMD_RIGHT) begin
        if (!in_i.phase_b) begin
          if (rticks_q != TICK_HI) rticks_d = rticks_q + TW'(1);
        end else begin
          if (rticks_q != TICK_LO) rticks_d = rticks_q - TW'(1);
        end
      end else if (in_i.command == CMD_TICK) begin
        if (ms_inc >= period_q) begin
          ms_d    = '0;
          busy_d  = 1'b1;
          pc_d    = '0;
          wheel_d = 1'b0;
        end else begin
          ms_d = ms_inc;
        end
      end else begin
        ms_d = ms_q;
      end
    end

    if (busy_q) begin
      if (uc.upd_sum && drv_sel != DRV_MAX && drv_sel != DRV_MIN) begin
        if (wheel_q) rsum_d = sum_new;
        else lsum_d = sum_new;
      end
      if (uc.ld_drive) begin
        if (wheel_q) rdrv_d = drv_calc;
        else ldrv_d = drv_calc;
      end
      unique case (uc.seq)
        SQ_NEXT: pc_d = pc_q + UC_PC_W'(1);
        SQ_LOOP: begin
          if (!wheel_q) begin
            wheel_d = 1'b1;
            pc_d    = uc.jump;
          end else if (finish) begin
            busy_d   = 1'b0;
            oval_d   = 1'b1;
            lticks_d = '0;
            rticks_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pc_q     <= '0;
      wheel_q  <= 1'b0;
      ms_q     <= '0;
      lticks_q <= '0;
      rticks_q <= '0;
      lsum_q   <= '0;
      rsum_q   <= '0;
      ldrv_q   <= '0;
      rdrv_q   <= '0;
      oval_q   <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pc_q     <= pc_d;
      wheel_q  <= wheel_d;
      ms_q     <= ms_d;
      lticks_q <= lticks_d;
      rticks_q <= rticks_d;
      lsum_q   <= lsum_d;
      rsum_q   <= rsum_d;
      ldrv_q   <= ldrv_d;
      rdrv_q   <= rdrv_d;
      oval_q   <= oval_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.command == CMD_TICK) begin
      v_q <= in_i.target_speed;
      w_q <= in_i.target_turn_rate;
    end
    if (busy_q) begin
      prod_q <= prod_full;
      if (uc.ld_delta) delta_q <= prod_rnd16[16 +: DELTA_W];
      if (uc.ld_targ) begin
        targ_q <= wheel_q ? TARG_W'(v_q) + TARG_W'(delta_q)
                          : TARG_W'(v_q) - TARG_W'(delta_q);
      end
      if (uc.ld_err) err_q <= ERR_W'(targ_q) - ERR_W'(meas);
      if (uc.ld_acc) acc_q <= ACC_W'(prod_q);
      if (uc.add_acc) acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (finish) begin
      lduty_q <= lmag[DUTY_W-1:0];
      lrev_q  <= ldrv_q[DRIVE_W-1];
      rduty_q <= rmag[DUTY_W-1:0];
      rrev_q  <= drv_calc[DRIVE_W-1];
    end
  end

  assign out_o.valid         = oval_q;
  assign out_o.left_duty     = lduty_q;
  assign out_o.left_reverse  = lrev_q;
  assign out_o.right_duty    = rduty_q;
  assign out_o.right_reverse = rrev_q;

endmodule

// ===== rtl/dwpi_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the dual wheel speed PI controller
// Watches the channels of the core and flags results that break its rules.
// ----------------------------------------------------------------------------
module dwpi_checker
  import dwpi_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [1:0]        in_command_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DUTY_W-1:0] left_duty_i,
  input logic              left_reverse_i,
  input logic [DUTY_W-1:0] right_duty_i,
  input logic              right_reverse_i
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_duty_i)
      && $stable(left_reverse_i) && $stable(right_duty_i) && $stable(right_reverse_i))
    else $error("result beat changed while stalled");

  // A reverse drive always has a nonzero magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!left_reverse_i || left_duty_i != '0)
      && (!right_reverse_i || right_duty_i != '0))
    else $error("reverse flag with zero duty");

  // An encoder edge never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i != CMD_TICK && !out_valid_i |=> !out_valid_i)
    else $error("result after an encoder edge");

  // A result only follows a running update, which holds the input off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without an update in progress");

endmodule

bind dual_wheel_speed_pi_controller_core dwpi_checker u_dwpi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_command_i    (in_i.command),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .left_duty_i     (out_o.left_duty),
  .left_reverse_i  (out_o.left_reverse),
  .right_duty_i    (out_o.right_duty),
  .right_reverse_i (out_o.right_reverse)
);
